// ===== hw/rtl/pcps_pkg.sv =====
// ----------------------------------------------------------------------------
// pcps_pkg
// Types and constants shared by the periodic cutoff pair search unit.
// ----------------------------------------------------------------------------
package pcps_pkg;

    localparam int COORD_W  = 32;
    localparam int LEN_W    = 31;
    localparam int CNT_W    = 12;
    localparam int FI_W     = 6;
    localparam int DIFF_W   = 34;
    localparam int RES_CAP  = 63;
    localparam int CFG_AW   = 2;
    localparam int SQ_W     = 62;
    localparam int SUM_W    = 64;
    localparam logic [CNT_W-1:0] CNT_MAX = 12'd4095;

    typedef enum logic [CFG_AW-1:0] {
        CFG_CUTOFF = 2'd0,
        CFG_BOX_X  = 2'd1,
        CFG_BOX_Y  = 2'd2,
        CFG_BOX_Z  = 2'd3
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CUT,
        S_CUTW,
        S_RD,
        S_RDW,
        S_START,
        S_DIV,
        S_SQ,
        S_ACC,
        S_CMP,
        S_FLUSH
    } t_state;

    typedef struct packed {
        logic                     start;
        logic signed [DIFF_W-1:0] diff;
        logic [LEN_W-1:0]         len;
    } t_wrap_req;

    typedef struct packed {
        logic                      done;
        logic signed [COORD_W-1:0] delta;
    } t_wrap_rsp;

endpackage

// ===== hw/rtl/pcps_pos_if.sv =====
// ----------------------------------------------------------------------------
// pcps_pos_if
// Atom position channel: one atom per beat.
// ----------------------------------------------------------------------------
interface pcps_pos_if;
    import pcps_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic                      frame_end;

    modport source (output valid, pos_x, pos_y, pos_z, frame_end, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, frame_end, output ready);
endinterface

// ===== hw/rtl/pcps_pair_if.sv =====
// ----------------------------------------------------------------------------
// pcps_pair_if
// Pair channel: one neighbor pair per beat.
// ----------------------------------------------------------------------------
interface pcps_pair_if;
    import pcps_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [FI_W-1:0]           first_index;
    logic [CNT_W-1:0]          second_index;
    logic signed [COORD_W-1:0] delta_x;
    logic signed [COORD_W-1:0] delta_y;
    logic signed [COORD_W-1:0] delta_z;
    logic                      run_last;
    logic                      store_overflow;

    modport source (output valid, first_index, second_index, delta_x, delta_y, delta_z,
                    run_last, store_overflow, input ready);
    modport sink   (input valid, first_index, second_index, delta_x, delta_y, delta_z,
                    run_last, store_overflow, output ready);
endinterface

// ===== hw/rtl/pcps_atom_mem.sv =====
// ----------------------------------------------------------------------------
// pcps_atom_mem
// Stored atom positions: one write port, one registered read port.
// ----------------------------------------------------------------------------
module pcps_atom_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int W     = 96
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);
    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hw/rtl/pcps_wrap.sv =====
// ----------------------------------------------------------------------------
// pcps_wrap
// Minimum-image wrap of one displacement: bit-serial remainder by the doubled
// box length, one quotient bit per cycle over 35 bits, then a registered
// result.
// ----------------------------------------------------------------------------
module pcps_wrap (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pcps_pkg::t_wrap_req i_req,
    output pcps_pkg::t_wrap_rsp o_rsp
);
    import pcps_pkg::*;

    localparam int NUM_W = DIFF_W + 1;
    localparam int CW    = $clog2(NUM_W + 1);

    logic                    r_busy;
    logic [CW-1:0]           r_cnt;
    logic [NUM_W-1:0]        r_num;
    logic [31:0]             r_rem;
    logic [31:0]             r_l;
    logic                    r_neg;
    logic                    r_done;
    logic signed [COORD_W-1:0] r_delta;

    logic [31:0]             l_in;
    logic signed [NUM_W:0]   s_dd;
    logic signed [NUM_W:0]   s_l;
    logic signed [NUM_W:0]   s_num;
    logic                    neg_in;
    logic [32:0]             t_rem;
    logic [32:0]             l2;
    logic [31:0]             n_rem;
    logic signed [33:0]      w;

    always_comb begin
        l_in   = (i_req.len == '0) ? 32'd1 : {1'b0, i_req.len};
        s_dd   = (NUM_W+1)'(signed'({i_req.diff, 1'b0}));
        s_l    = signed'((NUM_W+1)'(l_in));
        neg_in = s_dd < -s_l;
        s_num  = neg_in ? (-s_l - s_dd) : (s_dd + s_l);
        l2     = {r_l, 1'b0};
        t_rem  = {r_rem, r_num[NUM_W-1]};
        n_rem  = (t_rem >= l2) ? 32'(t_rem - l2) : t_rem[31:0];
        w      = r_neg ? (signed'({2'b0, r_l}) - signed'({2'b0, n_rem}))
                       : (signed'({2'b0, n_rem}) - signed'({2'b0, r_l}));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NUM_W);
                r_num  <= NUM_W'(s_num);
                r_rem  <= '0;
                r_l    <= l_in;
                r_neg  <= neg_in;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_num <= {r_num[NUM_W-2:0], 1'b0};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy  <= 1'b0;
                    r_done  <= 1'b1;
                    r_delta <= COORD_W'(w >>> 1);
                end
            end
        end
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.delta = r_delta;
endmodule

// ===== hw/rtl/periodic_cutoff_pair_search_unit.sv =====
// ----------------------------------------------------------------------------
// periodic_cutoff_pair_search_unit
// All-pairs neighbor search with minimum-image wrap in a periodic box.
//
//   channel     dir  beat
//   i_pos_ch    in   one atom: pos_x/y/z, frame_end
//   o_pair_ch   out  one pair: first/second index, delta_x/y/z, flags
//   i_cfg_*     in   register write: index, 31-bit data
//
// For each stored atom compared, the unit reads it; then for each axis it
// starts a 35-bit serial remainder, squares the wrapped delta and adds it;
// last it compares the sum with the squared cutoff.
// The input is not ready until the atom is finished.
// Reset is synchronous, active low; stored positions are not cleared.
// A stalled pair output, with a pair already pending, holds the search at the next hit or at the end.
// ----------------------------------------------------------------------------
module periodic_cutoff_pair_search_unit #(
    parameter int MAX_ATOMS  = 64,
    parameter int COORD_BITS = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    pcps_pos_if.sink                    i_pos_ch,
    pcps_pair_if.source                 o_pair_ch,
    input  logic                        i_cfg_we,
    input  logic [pcps_pkg::CFG_AW-1:0] i_cfg_idx,
    input  logic [pcps_pkg::LEN_W-1:0]  i_cfg_data
);
    import pcps_pkg::*;

    localparam int POS_BITS = (COORD_BITS < 32) ? COORD_BITS : 32;
    localparam int AW       = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
    localparam int IW       = AW + 1;
    localparam int PAIR_CAP = (MAX_ATOMS - 1 < RES_CAP) ? MAX_ATOMS - 1 : RES_CAP;
    localparam int MW       = 3 * POS_BITS;

    t_state r_state, n_state;

    logic [LEN_W-1:0] r_cut, r_lx, r_ly, r_lz;
    logic [CNT_W-1:0] r_cnt;

    logic signed [POS_BITS-1:0] r_px, r_py, r_pz;
    logic              r_fend;
    logic [CNT_W-1:0]  r_j;
    logic              r_ovf;
    logic [IW-1:0]     r_held;
    logic [IW-1:0]     r_i;
    logic [FI_W-1:0]   r_n;
    logic [1:0]        r_axis;
    logic [MW-1:0]     r_atom;
    logic [SQ_W-1:0]   r_prod;
    logic [SQ_W-1:0]   r_cut2;
    logic [SUM_W-1:0]  r_sum;
    logic signed [COORD_W-1:0] r_dx, r_dy, r_dz;

    logic              r_pd_v;
    logic [FI_W-1:0]   r_pd_fi;
    logic signed [COORD_W-1:0] r_pd_dx, r_pd_dy, r_pd_dz;

    logic              r_out_v;
    logic [FI_W-1:0]   r_out_fi;
    logic [CNT_W-1:0]  r_out_j;
    logic signed [COORD_W-1:0] r_out_dx, r_out_dy, r_out_dz;
    logic              r_out_last;
    logic              r_out_ovf;

    logic [MW-1:0]     mem_rdata;
    logic              mem_we;
    t_wrap_req         wrap_req;
    t_wrap_rsp         wrap_rsp;

    logic              accept;
    logic              wrap_start;
    logic              out_busy;
    logic              more;
    logic              hit;
    logic              ld_mid, ld_last, pd_load, done_item;
    logic              ovf_in;
    logic signed [POS_BITS-1:0] sp, sq;
    logic [LEN_W-1:0]  len_sel;
    logic [30:0]       abs_d;
    logic [30:0]       mul_a;

    // -------------------------------------------------------------- config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cut <= '0;
            r_lx  <= LEN_W'(65536);
            r_ly  <= LEN_W'(65536);
            r_lz  <= LEN_W'(65536);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_CUTOFF: r_cut <= i_cfg_data;
                CFG_BOX_X:  r_lx  <= i_cfg_data;
                CFG_BOX_Y:  r_ly  <= i_cfg_data;
                CFG_BOX_Z:  r_lz  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------ datapath
    always_comb begin
        out_busy = r_out_v && !o_pair_ch.ready;
        more     = (r_i < r_held) && (r_n < FI_W'(PAIR_CAP));
        hit      = r_sum < SUM_W'(r_cut2);
        ovf_in   = 32'(r_cnt) >= 32'(MAX_ATOMS);
        unique case (r_axis)
            2'd0: begin
                sp = r_px; sq = r_atom[POS_BITS-1:0]; len_sel = r_lx;
            end
            2'd1: begin
                sp = r_py; sq = r_atom[2*POS_BITS-1:POS_BITS]; len_sel = r_ly;
            end
            default: begin
                sp = r_pz; sq = r_atom[3*POS_BITS-1:2*POS_BITS]; len_sel = r_lz;
            end
        endcase
        wrap_req.start = wrap_start;
        wrap_req.diff  = DIFF_W'(sp) - DIFF_W'(sq);
        wrap_req.len   = len_sel;
        abs_d = wrap_rsp.delta[COORD_W-1] ? 31'(-wrap_rsp.delta) : 31'(wrap_rsp.delta);
        mul_a = (r_state == S_CUT) ? r_cut : abs_d;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_pos_ch.valid) n_state = S_CUT;
            S_CUT:   n_state = S_CUTW;
            S_CUTW:  n_state = S_RD;
            S_RD:    n_state = more ? S_RDW : S_FLUSH;
            S_RDW:   n_state = S_START;
            S_START: n_state = S_DIV;
            S_DIV:   if (wrap_rsp.done) n_state = S_SQ;
            S_SQ:    n_state = S_ACC;
            S_ACC:   n_state = (r_axis == 2'd2) ? S_CMP : S_START;
            S_CMP:   if (!(hit && r_pd_v && out_busy)) n_state = S_RD;
            S_FLUSH: if (!(r_pd_v && out_busy)) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control strobes
    always_comb begin
        accept     = 1'b0;
        wrap_start = 1'b0;
        ld_mid     = 1'b0;
        ld_last    = 1'b0;
        pd_load    = 1'b0;
        done_item  = 1'b0;
        unique case (r_state)
            S_IDLE:  accept = i_pos_ch.valid;
            S_START: wrap_start = 1'b1;
            S_CMP: begin
                if (hit && !(r_pd_v && out_busy)) begin
                    pd_load = 1'b1;
                    ld_mid  = r_pd_v;
                end
            end
            S_FLUSH: begin
                if (!(r_pd_v && out_busy)) begin
                    done_item = 1'b1;
                    ld_last   = r_pd_v;
                end
            end
            default: ;
        endcase
    end

    assign i_pos_ch.ready = (r_state == S_IDLE);
    assign mem_we         = done_item && !r_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_pd_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_state <= n_state;
            if (done_item) begin
                r_pd_v <= 1'b0;
                if (r_fend) begin
                    r_cnt <= '0;
                end else if (r_cnt < CNT_MAX) begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end else if (pd_load) begin
                r_pd_v <= 1'b1;
            end
            if (ld_mid || ld_last) begin
                r_out_v <= 1'b1;
            end else if (o_pair_ch.ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= SQ_W'(mul_a * mul_a);
        if (accept) begin
            r_px   <= i_pos_ch.pos_x[POS_BITS-1:0];
            r_py   <= i_pos_ch.pos_y[POS_BITS-1:0];
            r_pz   <= i_pos_ch.pos_z[POS_BITS-1:0];
            r_fend <= i_pos_ch.frame_end;
            r_j    <= r_cnt;
            r_ovf  <= ovf_in;
            r_held <= ovf_in ? IW'(MAX_ATOMS) : IW'(r_cnt);
            r_i    <= '0;
            r_n    <= '0;
        end
        if (r_state == S_CUTW) begin
            r_cut2 <= r_prod;
        end
        if (r_state == S_RDW) begin
            r_atom <= mem_rdata;
            r_axis <= 2'd0;
            r_sum  <= '0;
        end
        if (r_state == S_SQ) begin
            unique case (r_axis)
                2'd0:    r_dx <= wrap_rsp.delta;
                2'd1:    r_dy <= wrap_rsp.delta;
                default: r_dz <= wrap_rsp.delta;
            endcase
        end
        if (r_state == S_ACC) begin
            r_sum  <= r_sum + SUM_W'(r_prod);
            r_axis <= r_axis + 1'b1;
        end
        if (r_state == S_CMP && n_state == S_RD) begin
            r_i <= r_i + 1'b1;
        end
        if (pd_load) begin
            r_n     <= r_n + 1'b1;
            r_pd_fi <= FI_W'(r_i);
            r_pd_dx <= r_dx;
            r_pd_dy <= r_dy;
            r_pd_dz <= r_dz;
        end
        if (ld_mid || ld_last) begin
            r_out_fi   <= r_pd_fi;
            r_out_j    <= r_j;
            r_out_dx   <= r_pd_dx;
            r_out_dy   <= r_pd_dy;
            r_out_dz   <= r_pd_dz;
            r_out_last <= ld_last;
            r_out_ovf  <= r_ovf;
        end
    end

    pcps_atom_mem #(
        .DEPTH (MAX_ATOMS),
        .AW    (AW),
        .W     (MW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_j[AW-1:0]),
        .i_wdata ({r_pz, r_py, r_px}),
        .i_raddr (r_i[AW-1:0]),
        .o_rdata (mem_rdata)
    );

    pcps_wrap u_wrap (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (wrap_req),
        .o_rsp   (wrap_rsp)
    );

    assign o_pair_ch.valid          = r_out_v;
    assign o_pair_ch.first_index    = r_out_fi;
    assign o_pair_ch.second_index   = r_out_j;
    assign o_pair_ch.delta_x        = r_out_dx;
    assign o_pair_ch.delta_y        = r_out_dy;
    assign o_pair_ch.delta_z        = r_out_dz;
    assign o_pair_ch.run_last       = r_out_last;
    assign o_pair_ch.store_overflow = r_out_ovf;

    a_no_pend_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_pd_v)
        else $error("pending pair left after atom finished");

    a_pair_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_n <= FI_W'(PAIR_CAP)))
        else $error("pair count beyond cap");

    a_no_store_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> !r_ovf)
        else $error("store on overflow");

    a_wrap_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wrap_rsp.done |-> (r_state == S_DIV))
        else $error("wrap result outside divide phase");
endmodule
